FILE: hdl/lru_cache_set_assert.svh
// Assertion macros for the LRU cache set.
// Used by lru_cache_set.sv; relies on clock and reset being in scope.
`ifndef LRU_CACHE_SET_ASSERT_SVH
`define LRU_CACHE_SET_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define LCS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lru_cache_set: same-cycle check failed");

// Next-cycle implication, idle during reset.
`define LCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lru_cache_set: next-cycle check failed");

`endif

FILE: hdl/lcs_pkg.sv
// Package for the LRU cache set: operation codes, word structs, cell control.
// No dependencies.
package lcs_pkg;

   localparam int WAYS_DEFAULT     = 8;
   localparam int TAG_BITS_DEFAULT = 32;
   localparam int IO_TAG_BITS      = 32;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FILL  = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   // Request word
   typedef struct packed {
      op_type                   operation;
      logic [IO_TAG_BITS-1:0]   tag_in;
   } req_type;

   // Response word
   typedef struct packed {
      logic                     hit;
      logic [IO_TAG_BITS-1:0]   victim_tag;
      logic                     victim_valid;
      logic                     victim_dirty;
   } rsp_type;

   // Per-cycle control broadcast to every cell
   typedef struct packed {
      logic lookup;  // accepted read or write
      logic fill;    // accepted fill
      logic flush;   // accepted flush
   } lcs_ctrl_type;

endpackage

FILE: hdl/lcs_cell.sv
// One recency slot of the LRU cache set: tag, valid and dirty of one entry.
// Depends on lcs_pkg. Slots are chained newest to oldest.
module lcs_cell import lcs_pkg::*; #(
   parameter int TAG_BITS = TAG_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  lcs_ctrl_type        ctrl,
   input  logic [TAG_BITS-1:0] lookup_tag,
   // a lookup hit somewhere in the chain
   input  logic                any_hit,
   // entry handed down from the newer neighbor
   input  logic [TAG_BITS-1:0] prev_tag,
   input  logic                prev_valid,
   input  logic                prev_dirty,
   // match-seen chain
   input  logic                seen_in,
   output logic                seen_out,
   // selected-entry chain (first match, newest side)
   input  logic [TAG_BITS-1:0] sel_tag_in,
   input  logic                sel_dirty_in,
   output logic [TAG_BITS-1:0] sel_tag_out,
   output logic                sel_dirty_out,
   // current contents
   output logic [TAG_BITS-1:0] cur_tag,
   output logic                cur_valid,
   output logic                cur_dirty,
   // contents after this cycle
   output logic [TAG_BITS-1:0] nxt_tag,
   output logic                nxt_valid,
   output logic                nxt_dirty
);

   logic [TAG_BITS-1:0] tag_ff;
   logic [TAG_BITS-1:0] tag_in;
   logic                valid_ff;
   logic                valid_in;
   logic                dirty_ff;
   logic                dirty_in;
   logic                match;
   logic                first;
   logic                shift;

   // Tag compare and priority chain
   assign match         = ctrl.lookup & valid_ff & (tag_ff == lookup_tag);
   assign first         = match & ~seen_in;
   assign seen_out      = seen_in | match;
   assign sel_tag_out   = sel_tag_in | (first ? tag_ff : '0);
   assign sel_dirty_out = sel_dirty_in | (first & dirty_ff);

   // Slots up to and including the hit slot move one older; fill moves all
   assign shift = ctrl.fill | (ctrl.lookup & any_hit & ~seen_in);

   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      if (ctrl.flush) begin
         valid_in = 1'b0;
         dirty_in = 1'b0;
      end else if (shift) begin
         tag_in   = prev_tag;
         valid_in = prev_valid;
         dirty_in = prev_dirty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
      end else begin
         tag_ff   <= tag_in;
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
      end
   end

   assign cur_tag   = tag_ff;
   assign cur_valid = valid_ff;
   assign cur_dirty = dirty_ff;
   assign nxt_tag   = tag_in;
   assign nxt_valid = valid_in;
   assign nxt_dirty = dirty_in;

endmodule

FILE: hdl/lru_cache_set.sv
// LRU cache set, top level: each accepted request word yields a registered response word.
// Throughput one word per cycle while req_stall is low; the slot chain compare
// and reorder complete in the accept cycle, so the next word sees the updated order.
// Output register decouples the sides; req_stall follows rsp_stall on a held word.
// Synchronous reset empties every slot; req_stall is high during it.
// Depends on lcs_pkg, lcs_cell and lru_cache_set_assert.svh.
`include "lru_cache_set_assert.svh"

module lru_cache_set import lcs_pkg::*; #(
   parameter int WAYS     = WAYS_DEFAULT,
   parameter int TAG_BITS = TAG_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int TagCopy = (TAG_BITS < IO_TAG_BITS) ? TAG_BITS : IO_TAG_BITS;

   logic                accept;
   lcs_ctrl_type        ctrl;
   logic [TAG_BITS-1:0] lookup_tag;
   logic [TAG_BITS-1:0] ins_tag;
   logic                ins_dirty;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;

   logic [TAG_BITS-1:0] cur_tag   [WAYS];
   logic                cur_valid [WAYS];
   logic                cur_dirty [WAYS];
   logic [TAG_BITS-1:0] nxt_tag   [WAYS];
   logic                nxt_valid [WAYS];
   logic                nxt_dirty [WAYS];
   logic                seen      [WAYS+1];
   logic [TAG_BITS-1:0] sel_tag   [WAYS+1];
   logic                sel_dirty [WAYS+1];
   logic [WAYS-1:0]     dirty_bad;

   // Handshake
   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   // Decode
   always_comb begin
      ctrl.lookup = accept & ((req_data.operation == OP_READ) ||
                              (req_data.operation == OP_WRITE));
      ctrl.fill   = accept & (req_data.operation == OP_FILL);
      ctrl.flush  = accept & (req_data.operation == OP_FLUSH);
   end

   always_comb begin
      lookup_tag = '0;
      lookup_tag[TagCopy-1:0] = req_data.tag_in[TagCopy-1:0];
   end

   // Entry inserted at the newest slot: new tag on fill, promoted hit otherwise
   always_comb begin
      if (ctrl.fill) begin
         ins_tag   = lookup_tag;
         ins_dirty = 1'b0;
      end else begin
         ins_tag   = sel_tag[WAYS];
         ins_dirty = sel_dirty[WAYS] | (req_data.operation == OP_WRITE);
      end
   end

   assign seen[0]      = 1'b0;
   assign sel_tag[0]   = '0;
   assign sel_dirty[0] = 1'b0;

   // Slot chain, newest at index 0
   for (genvar i = 0; i < WAYS; i++) begin : g_slot
      logic [TAG_BITS-1:0] p_tag;
      logic                p_valid;
      logic                p_dirty;

      if (i == 0) begin : g_head
         assign p_tag   = ins_tag;
         assign p_valid = 1'b1;
         assign p_dirty = ins_dirty;
      end else begin : g_link
         assign p_tag   = cur_tag[i-1];
         assign p_valid = cur_valid[i-1];
         assign p_dirty = cur_dirty[i-1];
      end

      lcs_cell #(
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .lookup_tag    (lookup_tag),
         .any_hit       (seen[WAYS]),
         .prev_tag      (p_tag),
         .prev_valid    (p_valid),
         .prev_dirty    (p_dirty),
         .seen_in       (seen[i]),
         .seen_out      (seen[i+1]),
         .sel_tag_in    (sel_tag[i]),
         .sel_dirty_in  (sel_dirty[i]),
         .sel_tag_out   (sel_tag[i+1]),
         .sel_dirty_out (sel_dirty[i+1]),
         .cur_tag       (cur_tag[i]),
         .cur_valid     (cur_valid[i]),
         .cur_dirty     (cur_dirty[i]),
         .nxt_tag       (nxt_tag[i]),
         .nxt_valid     (nxt_valid[i]),
         .nxt_dirty     (nxt_dirty[i])
      );

      assign dirty_bad[i] = cur_dirty[i] & ~cur_valid[i];
   end

   // Response word: hit plus the oldest slot after the update
   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.hit          = ctrl.lookup & seen[WAYS];
      rsp_data_in.victim_tag[TagCopy-1:0] = nxt_tag[WAYS-1][TagCopy-1:0];
      rsp_data_in.victim_valid = nxt_valid[WAYS-1];
      rsp_data_in.victim_dirty = nxt_dirty[WAYS-1];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `LCS_ASSERT_NOW(a_dirty_only_valid, 1'b1, dirty_bad == '0)
   `LCS_ASSERT_NEXT(a_fill_no_hit, ctrl.fill || ctrl.flush, rsp_valid && !rsp_data.hit)
   `LCS_ASSERT_NEXT(a_flush_empty, ctrl.flush, !rsp_data.victim_valid && !rsp_data.victim_dirty)
   `LCS_ASSERT_NEXT(a_fill_newest, ctrl.fill, cur_valid[0] && !cur_dirty[0])

endmodule

FILE: bench/tb_lru_cache_set.sv
// Self-checking bench for lru_cache_set: directed and random accesses with a
// clocked driver and monitor, checked against a rank-based true-LRU predictor.
// Depends on lcs_pkg and the lru_cache_set RTL.
module tb_lru_cache_set;
   import lcs_pkg::*;

   localparam int NWAYS     = WAYS_DEFAULT;
   localparam int POOL_SIZE = 12;
   localparam int CALM_TAIL = 120;

   typedef struct {
      req_type word;
      bit      drain_first;   // hold this word until every result is back
   } pending_access_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   lru_cache_set dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Predicted set contents
   logic [IO_TAG_BITS-1:0] way_tag   [NWAYS];
   bit                     way_live  [NWAYS];
   bit                     way_dirty [NWAYS];
   int                     way_rank  [NWAYS];

   pending_access_type     pending_words [$];
   rsp_type                expected_rsp  [$];
   logic [IO_TAG_BITS-1:0] tag_pool      [POOL_SIZE];

   bit req_taken  = 1'b0;
   int send_gap   = 0;
   int stall_left = 0;
   int errors     = 0;
   int n_hits     = 0;
   int n_misses   = 0;
   int n_fills    = 0;
   int n_flushes  = 0;
   int n_results  = 0;

   // No idling once the queue runs low
   function automatic bit calm();
      return pending_words.size() < CALM_TAIL;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor
   function automatic void promote_way(int w);
      int old_rank;
      old_rank = way_rank[w];
      for (int i = 0; i < NWAYS; i++)
         if (way_rank[i] < old_rank) way_rank[i]++;
      way_rank[w] = 0;
   endfunction

   function automatic int lru_way();
      int v;
      v = 0;
      for (int i = 0; i < NWAYS; i++)
         if (way_rank[i] == NWAYS - 1) v = i;
      return v;
   endfunction

   function automatic rsp_type apply_access(req_type w);
      int      match;
      int      v;
      rsp_type r;
      match = -1;
      r = '0;
      case (w.operation)
         OP_READ, OP_WRITE: begin
            // most recent matching way wins when a tag is duplicated
            for (int i = 0; i < NWAYS; i++)
               if (way_live[i] && way_tag[i] == w.tag_in &&
                   (match < 0 || way_rank[i] < way_rank[match]))
                  match = i;
            if (match >= 0) begin
               r.hit = 1'b1;
               if (w.operation == OP_WRITE) way_dirty[match] = 1'b1;
               promote_way(match);
               n_hits++;
            end else begin
               n_misses++;
            end
         end
         OP_FILL: begin
            v = lru_way();
            way_tag[v]   = w.tag_in;
            way_live[v]  = 1'b1;
            way_dirty[v] = 1'b0;
            promote_way(v);
            n_fills++;
         end
         default: begin
            for (int i = 0; i < NWAYS; i++) begin
               way_live[i]  = 1'b0;
               way_dirty[i] = 1'b0;
            end
            n_flushes++;
         end
      endcase
      v = lru_way();
      r.victim_tag   = way_tag[v];
      r.victim_valid = way_live[v];
      r.victim_dirty = way_dirty[v];
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   task automatic queue_access(op_type op, logic [IO_TAG_BITS-1:0] tag, bit drain = 1'b0);
      pending_access_type p;
      p.word.operation = op;
      p.word.tag_in    = tag;
      p.drain_first    = drain;
      pending_words.push_back(p);
   endtask

   // Driver: next word at the falling edge once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_words[0].drain_first &&
                      (expected_rsp.size() != 0 || (req_valid && !req_taken))) begin
            req_valid <= 1'b0;
         end else if (!calm() && $urandom_range(0, 9) == 0) begin
            send_gap  <= $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_words[0].word;
            pending_words.pop_front();
         end
      end
   end

   // Receiver back-pressure in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!calm() && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            expected_rsp.push_back(apply_access(req_data));
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected response word, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_data.hit));
               check_field("victim_tag", want.victim_tag, rsp_data.victim_tag);
               check_field("victim_valid", 32'(want.victim_valid),
                           32'(rsp_data.victim_valid));
               check_field("victim_dirty", 32'(want.victim_dirty),
                           32'(rsp_data.victim_dirty));
            end
         end
      end
   end

   // Watchdog
   initial begin
      #2000000;
      $display("lru_cache_set regression: fail");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      int     r;
      op_type op;
      logic [IO_TAG_BITS-1:0] tag;

      for (int i = 0; i < NWAYS; i++) begin
         way_tag[i]   = '0;
         way_live[i]  = 1'b0;
         way_dirty[i] = 1'b0;
         way_rank[i]  = i;
      end

      // directed: empty set, extremes, full set, duplicate tags, flush
      queue_access(OP_READ,  32'h0000_0000);  // tag zero on invalid ways misses
      queue_access(OP_WRITE, 32'hFFFF_FFFF);
      queue_access(OP_FILL,  32'h0000_0000);
      queue_access(OP_READ,  32'h0000_0000);
      queue_access(OP_FILL,  32'hFFFF_FFFF);
      queue_access(OP_WRITE, 32'hFFFF_FFFF);
      queue_access(OP_FILL,  32'h8000_0000);
      queue_access(OP_FILL,  32'h0000_0001);
      queue_access(OP_FILL,  32'h7FFF_FFFF);
      queue_access(OP_FILL,  32'hA5A5_A5A5);
      queue_access(OP_FILL,  32'h5A5A_5A5A);
      queue_access(OP_FILL,  32'hC3C3_C3C3);
      queue_access(OP_WRITE, 32'h0000_0000);  // oldest way hit, victim moves on
      queue_access(OP_FILL,  32'hA5A5_A5A5);  // same tag now in two ways
      queue_access(OP_WRITE, 32'hA5A5_A5A5);
      queue_access(OP_READ,  32'h1234_5678);
      queue_access(OP_READ,  32'hFFFF_FFFF);
      queue_access(OP_FLUSH, 32'hFFFF_FFFF);
      queue_access(OP_READ,  32'hFFFF_FFFF);
      queue_access(OP_WRITE, 32'h0000_0000);
      queue_access(OP_FILL,  32'hDEAD_BEEF);
      queue_access(OP_READ,  32'hDEAD_BEEF);

      // random: mostly a small tag pool so fills lead to hits
      tag_pool[0] = 32'h0000_0000;
      tag_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) tag_pool[i] = $urandom;
      for (int n = 0; n < 1250; n++) begin
         if (n % 100 == 99) tag_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
         r = $urandom_range(0, 99);
         if (r < 36)      op = OP_READ;
         else if (r < 68) op = OP_WRITE;
         else if (r < 97) op = OP_FILL;
         else             op = OP_FLUSH;
         if ($urandom_range(0, 99) < 85) tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
         else                            tag = $urandom;
         queue_access(op, tag, (n % 400) == 0);
      end

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d responses: %0d hits, %0d misses, %0d fills, %0d flushes",
               n_results, n_hits, n_misses, n_fills, n_flushes);
      $display("with random stalls on both sides and drain pauses; %0d mismatches", errors);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("lru_cache_set regression: pass");
      else
         $display("lru_cache_set regression: fail");
      $finish;
   end

endmodule
